// ===== rtl/pool_block_allocator_top_assert.svh =====
// assertion macros for the pool block allocator checker
// used by pba_checker only, no other dependencies
`ifndef POOL_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define POOL_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define PBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pool allocator check failed (same cycle)");

// next-cycle implication
`define PBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pool allocator check failed (next cycle)");

`endif

// ===== rtl/pba_pkg.sv =====
// shared types and constants of the pool block allocator
// no dependencies
`timescale 1ns / 1ps

package pba_pkg;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned HEADER_BYTES = 24;

  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NEED_W   = DATA_W + 1;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LEAK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'd1;

  typedef struct packed {
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] len;
    logic [DATA_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic read;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

// ===== rtl/pba_ram.sv =====
// generic simple dual-port ram, one write port, registered read port
// no dependencies
`timescale 1ns / 1ps

module pba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pba_ctrl.sv =====
// control state machine: accept, table scan, decision
// depends on pba_pkg
`timescale 1ns / 1ps

module pba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  pba_pkg::dp_sts_t sts,
  output pba_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.read = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/pba_dp.sv =====
// datapath: pool registers, block table, oldest-match scan and commit
// depends on pba_pkg and pba_ram
`timescale 1ns / 1ps

module pba_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pba_pkg::DATA_W-1:0]        cfg_data,
  input  logic [pba_pkg::OP_W-1:0]          in_op,
  input  logic [pba_pkg::DATA_W-1:0]        in_req_size,
  input  logic [pba_pkg::DATA_W-1:0]        in_block_address,
  input  pba_pkg::dp_cmd_t                  cmd,
  output pba_pkg::dp_sts_t                  sts,
  output logic                              out_valid,
  output logic [pba_pkg::DATA_W-1:0]        out_result_address,
  output logic [pba_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_was_reused
);

  localparam int unsigned IW = pba_pkg::IDX_W;
  localparam int unsigned CW = pba_pkg::CNT_W;
  localparam int unsigned DW = pba_pkg::DATA_W;
  localparam int unsigned NW = pba_pkg::NEED_W;

  // configuration and table control state
  logic [DW-1:0]               pool_base_r;
  logic [DW-1:0]               pool_size_r;
  logic [CW-1:0]               count_r;
  logic [pba_pkg::ENTRIES-1:0] busy_r;
  logic [DW-1:0]               stamp_cnt_r;
  logic [NW-1:0]               bump_r;

  // scan control
  logic [CW-1:0] idx_r;
  logic          pend_r;
  logic          found_r;
  logic          out_valid_r;

  // request and scan payload
  logic [pba_pkg::OP_W-1:0] op_r;
  logic [NW-1:0]            need_r;
  logic [DW-1:0]            baddr_r;
  logic [IW-1:0]            cmp_idx_r;
  logic [IW-1:0]            best_idx_r;
  logic [DW-1:0]            best_addr_r;
  logic [DW-1:0]            best_len_r;
  logic [DW-1:0]            best_age_r;

  logic [DW-1:0]                 out_addr_r;
  logic [pba_pkg::STATUS_W-1:0]  out_status_r;
  logic                          out_reused_r;

  pba_pkg::entry_t rd_data;
  pba_pkg::entry_t wr_data;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;

  logic          rd_busy;
  logic [DW-1:0] age;
  logic          match;
  logic          take;

  logic [NW:0]   space_sum;
  logic          no_space;
  logic          full;
  logic [DW-1:0] carve_addr;

  logic                         busy_wr;
  logic [IW-1:0]                busy_idx;
  logic                         busy_val;
  logic                         carve;
  logic                         stamp_inc;
  logic [DW-1:0]                res_addr;
  logic [pba_pkg::STATUS_W-1:0] res_status;
  logic                         res_reused;

  pba_ram #(
    .WIDTH ($bits(pba_pkg::entry_t)),
    .DEPTH (pba_pkg::ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx_r[IW-1:0]),
    .rdata (rd_data)
  );

  assign sts.scan_done = (idx_r >= count_r);

  // per-entry match against the request
  always_comb begin
    rd_busy = busy_r[cmp_idx_r];
    age     = stamp_cnt_r - rd_data.stamp;
    case (op_r)
      pba_pkg::OP_ALLOC: match = !rd_busy && ({1'b0, rd_data.len} >= need_r);
      pba_pkg::OP_FREE:  match = rd_busy && (rd_data.addr == baddr_r);
      default:           match = rd_busy;
    endcase
    take = pend_r && match && (!found_r || (age > best_age_r));
  end

  assign space_sum  = {1'b0, bump_r} + {1'b0, need_r};
  assign no_space   = space_sum > {2'b00, pool_size_r};
  assign full       = count_r >= CW'(pba_pkg::ENTRIES);
  assign carve_addr = pool_base_r + bump_r[DW-1:0];

  // decision at the end of the scan
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = best_idx_r;
    wr_data    = '{addr: best_addr_r, len: best_len_r, stamp: stamp_cnt_r};
    busy_wr    = 1'b0;
    busy_idx   = best_idx_r;
    busy_val   = 1'b0;
    carve      = 1'b0;
    stamp_inc  = 1'b0;
    res_addr   = '0;
    res_status = pba_pkg::ST_OK;
    res_reused = 1'b0;
    if (cmd.commit) begin
      case (op_r)
        pba_pkg::OP_ALLOC: begin
          if (found_r) begin
            wr_en      = 1'b1;
            busy_wr    = 1'b1;
            busy_val   = 1'b1;
            stamp_inc  = 1'b1;
            res_addr   = best_addr_r;
            res_reused = 1'b1;
          end else if (no_space) begin
            res_status = pba_pkg::ST_NO_SPACE;
          end else if (full) begin
            res_status = pba_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = count_r[IW-1:0];
            wr_data   = '{addr: carve_addr, len: need_r[DW-1:0], stamp: stamp_cnt_r};
            busy_wr   = 1'b1;
            busy_idx  = count_r[IW-1:0];
            busy_val  = 1'b1;
            carve     = 1'b1;
            stamp_inc = 1'b1;
            res_addr  = carve_addr;
          end
        end
        pba_pkg::OP_FREE: begin
          if (found_r) begin
            wr_en     = 1'b1;
            busy_wr   = 1'b1;
            stamp_inc = 1'b1;
          end else begin
            res_status = pba_pkg::ST_NOT_FND;
          end
        end
        default: begin
          if (found_r) begin
            res_addr = best_addr_r;
          end else begin
            res_status = pba_pkg::ST_EMPTY;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
      pool_size_r <= '0;
      count_r     <= '0;
      busy_r      <= '0;
      stamp_cnt_r <= '0;
      bump_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= cmd.read;
      out_valid_r <= cmd.commit;
      if (cfg_we) begin
        unique case (cfg_index)
          pba_pkg::CFG_POOL_BASE: pool_base_r <= cfg_data;
          pba_pkg::CFG_POOL_SIZE: pool_size_r <= cfg_data;
          default: ;
        endcase
        // a new pool empties the table
        count_r     <= '0;
        busy_r      <= '0;
        stamp_cnt_r <= '0;
        bump_r      <= '0;
      end else begin
        if (busy_wr) begin
          busy_r[busy_idx] <= busy_val;
        end
        if (stamp_inc) begin
          stamp_cnt_r <= stamp_cnt_r + 1'b1;
        end
        if (carve) begin
          count_r <= count_r + 1'b1;
          bump_r  <= bump_r + need_r;
        end
      end
      if (cmd.load) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.read) begin
          idx_r <= idx_r + 1'b1;
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      need_r  <= {1'b0, in_req_size} + NW'(pba_pkg::HEADER_BYTES);
      baddr_r <= in_block_address;
    end
    if (cmd.read) begin
      cmp_idx_r <= idx_r[IW-1:0];
    end
    if (take) begin
      best_idx_r  <= cmp_idx_r;
      best_addr_r <= rd_data.addr;
      best_len_r  <= rd_data.len;
      best_age_r  <= age;
    end
    if (cmd.commit) begin
      out_addr_r   <= res_addr;
      out_status_r <= res_status;
      out_reused_r <= res_reused;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;
  assign out_was_reused     = out_reused_r;

endmodule

// ===== rtl/pool_block_allocator_top.sv =====
// pool block allocator, top level
// depends on pba_pkg, pba_ctrl, pba_dp (and pba_ram through pba_dp)
`timescale 1ns / 1ps

// usage
//   request: drive in_op, in_req_size, in_block_address with start high; the
//   transfer happens at an edge where busy is low. op 0 allocates, 1 frees,
//   2 (and 3) asks for the oldest busy block.
//   result: out_valid is high for exactly one cycle with out_result_address,
//   out_status and out_was_reused; the receiver cannot stall it.
//   config: cfg_we with cfg_index 0 (pool base) or 1 (pool size) writes
//   cfg_data and empties the block table; write only when idle.
// timing
//   each request scans the N blocks carved so far, one table ram read per
//   cycle, then decides. the result shows in the same cycle that busy drops,
//   so a new request is taken only after the last one is through.
// reset
//   synchronous rst_n empties the table and clears pool base and size; no
//   clearing pass is needed, the block can take a request right after.
module pool_block_allocator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [pba_pkg::OP_W-1:0]          in_op,
  input  logic [pba_pkg::DATA_W-1:0]        in_req_size,
  input  logic [pba_pkg::DATA_W-1:0]        in_block_address,
  input  logic                              cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pba_pkg::DATA_W-1:0]        cfg_data,
  output logic                              out_valid,
  output logic [pba_pkg::DATA_W-1:0]        out_result_address,
  output logic [pba_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_was_reused
);

  pba_pkg::dp_cmd_t cmd;
  pba_pkg::dp_sts_t sts;

  pba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pba_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_op              (in_op),
    .in_req_size        (in_req_size),
    .in_block_address   (in_block_address),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .out_was_reused     (out_was_reused)
  );

endmodule

// ===== rtl/pba_checker.sv =====
// port-level checks of the pool block allocator, bound to the top level
// depends on pba_pkg and pool_block_allocator_top_assert.svh
`timescale 1ns / 1ps
`include "pool_block_allocator_top_assert.svh"

module pba_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [pba_pkg::DATA_W-1:0]        out_result_address,
  input logic [pba_pkg::STATUS_W-1:0]      out_status,
  input logic                              out_was_reused
);

  // a result comes only after the work is done
  `PBA_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)
  // an accepted transfer keeps the block busy
  `PBA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // one result per request, never two in a row
  `PBA_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // reuse only on a granted alloc
  `PBA_ASSERT_IMP(a_reuse_ok, clk, rst_n, out_valid && out_was_reused, out_status == pba_pkg::ST_OK)
  // failed requests report address zero
  `PBA_ASSERT_IMP(a_fail_addr, clk, rst_n, out_valid && (out_status != pba_pkg::ST_OK), out_result_address == '0)

endmodule

bind pool_block_allocator_top pba_checker u_pba_checker (.*);

// ===== tb/tb_pool_block_allocator_top.sv =====
// self-checking testbench of the pool block allocator: directed and random
// requests under several pool settings, checked against an allocator model
// depends on pba_pkg and pool_block_allocator_top
`timescale 1ns / 1ps

module tb_pool_block_allocator_top;
  import pba_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] req_size;
    logic [DATA_W-1:0] block_address;
  } pool_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
    logic                reused;
  } reply_t;

  typedef enum int {MATCH_ANY, MATCH_FITS, MATCH_ADDR} match_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_op;
  logic [DATA_W-1:0]    in_req_size;
  logic [DATA_W-1:0]    in_block_address;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;
  logic                 out_valid;
  logic [DATA_W-1:0]    out_result_address;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_was_reused;

  pool_block_allocator_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_req_size        (in_req_size),
    .in_block_address   (in_block_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .out_was_reused     (out_was_reused)
  );

  // allocator model state
  logic [DATA_W-1:0] base_reg;
  logic [DATA_W-1:0] size_reg;
  logic [DATA_W-1:0] blk_addr [ENTRIES];
  logic [DATA_W-1:0] blk_len [ENTRIES];
  logic [DATA_W-1:0] blk_stamp [ENTRIES];
  bit                blk_used [ENTRIES];
  bit                blk_taken [ENTRIES];
  logic [DATA_W-1:0] clock_tick;
  logic [NEED_W-1:0] carve_offset;
  int                blk_count;

  pool_req_t req_queue[$];
  reply_t    due_replies[$];
  bit        was_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        mismatches = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void clear_blocks();
    for (int i = 0; i < ENTRIES; i++) begin
      blk_used[i] = 1'b0;
      blk_taken[i] = 1'b0;
      blk_addr[i] = '0;
      blk_len[i] = '0;
      blk_stamp[i] = '0;
    end
    clock_tick = '0;
    carve_offset = '0;
    blk_count = 0;
  endfunction

  function automatic int oldest_block(bit taken, match_t how, logic [NEED_W-1:0] need,
                                      logic [DATA_W-1:0] addr);
    int best;
    logic [DATA_W-1:0] best_age;
    logic [DATA_W-1:0] age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!blk_used[i] || blk_taken[i] != taken) continue;
      if (how == MATCH_FITS && {1'b0, blk_len[i]} < need) continue;
      if (how == MATCH_ADDR && blk_addr[i] != addr) continue;
      age = clock_tick - blk_stamp[i];
      if (best < 0 || age > best_age) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic void stamp_block(int k);
    blk_stamp[k] = clock_tick;
    clock_tick = clock_tick + 1;
  endfunction

  function automatic reply_t serve_request(pool_req_t rq);
    reply_t rp;
    logic [NEED_W-1:0] need;
    int k;
    rp.addr = '0;
    rp.status = ST_OK;
    rp.reused = 1'b0;
    need = {1'b0, rq.req_size} + HEADER_BYTES;
    case (rq.op)
      OP_ALLOC: begin
        k = oldest_block(1'b0, MATCH_FITS, need, '0);
        if (k >= 0) begin
          blk_taken[k] = 1'b1;
          stamp_block(k);
          rp.addr = blk_addr[k];
          rp.reused = 1'b1;
        end else if (({1'b0, carve_offset} + {1'b0, need}) > {2'b00, size_reg}) begin
          rp.status = ST_NO_SPACE;
        end else if (blk_count >= ENTRIES) begin
          rp.status = ST_FULL;
        end else begin
          k = blk_count;
          blk_addr[k] = base_reg + carve_offset[DATA_W-1:0];
          blk_len[k] = need[DATA_W-1:0];
          blk_used[k] = 1'b1;
          blk_taken[k] = 1'b1;
          stamp_block(k);
          blk_count++;
          carve_offset = carve_offset + need;
          rp.addr = blk_addr[k];
        end
      end
      OP_FREE: begin
        k = oldest_block(1'b1, MATCH_ADDR, '0, rq.block_address);
        if (k >= 0) begin
          blk_taken[k] = 1'b0;
          stamp_block(k);
        end else begin
          rp.status = ST_NOT_FND;
        end
      end
      default: begin
        k = oldest_block(1'b1, MATCH_ANY, '0, '0);
        if (k >= 0) rp.addr = blk_addr[k];
        else rp.status = ST_EMPTY;
      end
    endcase
    return rp;
  endfunction

  // request drawn from the current table so frees mostly hit live blocks
  function automatic pool_req_t make_request(bit fill_mode);
    pool_req_t r;
    int busy_list[$];
    int free_list[$];
    int pick;
    int k;
    r.op = OP_ALLOC;
    r.req_size = $urandom();
    r.block_address = $urandom();
    for (int i = 0; i < ENTRIES; i++) begin
      if (blk_used[i] && blk_taken[i]) busy_list = {busy_list, i};
      if (blk_used[i] && !blk_taken[i]) free_list = {free_list, i};
    end
    pick = $urandom_range(0, 99);
    if (pick < (fill_mode ? 85 : 45)) begin
      case ($urandom_range(0, 9))
        0: r.req_size = $urandom();
        1, 2: begin
          if (free_list.size() > 0) begin
            k = free_list[$urandom_range(0, free_list.size() - 1)];
            r.req_size = blk_len[k] - HEADER_BYTES + $urandom_range(0, 2) - 1;
          end else begin
            r.req_size = $urandom_range(0, 300);
          end
        end
        3: begin
          if ({1'b0, size_reg} >= carve_offset + HEADER_BYTES)
            r.req_size = size_reg - carve_offset[DATA_W-1:0] - HEADER_BYTES;
          else
            r.req_size = $urandom_range(0, 64);
        end
        default: r.req_size = $urandom_range(0, 300);
      endcase
    end else if (pick < (fill_mode ? 93 : 88)) begin
      r.op = OP_FREE;
      if (busy_list.size() > 0 && $urandom_range(0, 5) != 0)
        r.block_address = blk_addr[busy_list[$urandom_range(0, busy_list.size() - 1)]];
      else if (free_list.size() > 0 && $urandom_range(0, 1) == 1)
        r.block_address = blk_addr[free_list[$urandom_range(0, free_list.size() - 1)]];
    end else begin
      r.op = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_LEAK;
    end
    return r;
  endfunction

  task automatic wait_slot();
    do @(posedge clk); while (req_queue.size() != 0);
  endtask

  task automatic wait_idle();
    while (req_queue.size() != 0 || due_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send(logic [OP_W-1:0] op, logic [DATA_W-1:0] size,
                      logic [DATA_W-1:0] addr);
    pool_req_t r;
    r.op = op;
    r.req_size = size;
    r.block_address = addr;
    wait_slot();
    req_queue = {req_queue, r};
  endtask

  task automatic feed(int n, bit fill_mode);
    repeat (n) begin
      wait_slot();
      req_queue = {req_queue, make_request(fill_mode)};
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POOL_BASE) base_reg = val;
    else size_reg = val;
    clear_blocks();
  endtask

  // driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin : drive_blk
    bit go;
    go = 1'b0;
    if (rst_n) begin
      if (start && was_taken) begin
        void'(req_queue.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(9, 90);
        end
      end
      if (gap_left > 0) gap_left--;
      else if (req_queue.size() > 0) go = 1'b1;
    end
    start <= go;
    if (go) begin
      in_op <= req_queue[0].op;
      in_req_size <= req_queue[0].req_size;
      in_block_address <= req_queue[0].block_address;
    end
  end

  // monitor: check the result strobe, then predict any new transfer
  always @(posedge clk) begin : watch_blk
    reply_t want;
    pool_req_t seen;
    if (rst_n && out_valid) begin
      if (due_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual addr %h status %0d reused %0b",
                 $time, out_result_address, out_status, out_was_reused);
        mismatches++;
      end else begin
        want = due_replies.pop_front();
        if (out_result_address !== want.addr) begin
          $display("%0t: result_address expected %h actual %h",
                   $time, want.addr, out_result_address);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatches++;
        end
        if (out_was_reused !== want.reused) begin
          $display("%0t: was_reused expected %0b actual %0b",
                   $time, want.reused, out_was_reused);
          mismatches++;
        end
      end
    end
    was_taken = rst_n && start && !busy;
    if (was_taken) begin
      seen = {in_op, in_req_size, in_block_address};
      due_replies = {due_replies, serve_request(seen)};
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_ALLOC;
    in_req_size = '0;
    in_block_address = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_POOL_BASE;
    cfg_data = '0;
    base_reg = '0;
    size_reg = '0;
    clear_blocks();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pool after reset
    send(OP_ALLOC, 32'd0, 32'd0);
    wait_idle();

    write_reg(CFG_POOL_BASE, 32'h0000_1000);
    write_reg(CFG_POOL_SIZE, 32'h0000_0400);
    send(OP_LEAK, 32'd0, 32'd0);
    send(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_FREE, 32'd0, 32'h0000_1000);
    send(OP_ALLOC, 32'd0, 32'd0);
    send(OP_ALLOC, 32'd40, 32'd0);
    send(OP_ALLOC, 32'd100, 32'd0);
    send(OP_LEAK, 32'd0, 32'd0);
    send(OP_FREE, 32'd0, 32'h0000_1018);
    send(OP_FREE, 32'd0, 32'h0000_1000);
    send(OP_LEAK, 32'd0, 32'd0);
    // earliest-freed fitting block wins
    send(OP_ALLOC, 32'd0, 32'd0);
    send(OP_ALLOC, 32'd0, 32'd0);
    send(OP_FREE, 32'd0, 32'h0000_1234);
    send(OP_FREE, 32'd0, 32'h0000_1018);
    send(OP_FREE, 32'd0, 32'h0000_1018);
    send(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send(OP_ALLOC, 32'd1000, 32'd0);
    send(OP_ALLOC, 32'd41, 32'd0);
    send(OP_ALLOC, 32'd40, 32'd0);
    wait_slot();
    send(OP_ALLOC, size_reg - carve_offset[DATA_W-1:0] - HEADER_BYTES, 32'd0);
    send(OP_ALLOC, 32'd0, 32'd0);
    wait_idle();

    // address wrap, then fill the table
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_POOL_SIZE, 32'hFFFF_FFFF);
    send(OP_ALLOC, 32'd0, 32'd0);
    send(OP_ALLOC, 32'hFFFF_FFE7, 32'd0);
    send(OP_ALLOC, 32'd0, 32'd0);
    feed(75, 1'b1);
    wait_idle();
    feed(75, 1'b1);
    wait_idle();

    write_reg(CFG_POOL_SIZE, 32'd0);
    feed(20, 1'b0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_POOL_BASE, (p == 0) ? 32'd0 : $urandom());
      write_reg(CFG_POOL_SIZE, (p == 0) ? 32'hFFFF_FFFF : $urandom_range(500, 30000));
      feed(90, 1'b0);
      wait_idle();
      feed(90, 1'b0);
      wait_idle();
    end

    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
